### design/cbsu_pkg.sv
// Shared types and constants for the branch and stack unit.
// No dependencies.
package cbsu_pkg;

  localparam int STACK_WORDS = 32768;
  localparam int SAW = $clog2(STACK_WORDS);
  localparam logic [4:0] LEVEL_MASK = 5'h1f;

  localparam logic [3:0] R_CW  = 4'd1;
  localparam logic [3:0] R_SP  = 4'd4;
  localparam logic [3:0] R_BP  = 4'd5;
  localparam logic [3:0] R_PS  = 4'd9;
  localparam logic [3:0] R_SS  = 4'd10;
  localparam logic [3:0] R_PC  = 4'd12;
  localparam logic [3:0] R_PSW = 4'd13;
  localparam int NREGS = 14;

  typedef enum logic [4:0] {
    OP_LOOP = 5'd0, OP_LOOPW = 5'd1, OP_JSHORT = 5'd2, OP_JCOND = 5'd3,
    OP_JNEAR = 5'd4, OP_JFAR = 5'd5, OP_CALLN = 5'd6, OP_CALLF = 5'd7,
    OP_RET = 5'd8, OP_RETI = 5'd9, OP_RETF = 5'd10, OP_RETFI = 5'd11,
    OP_IRET = 5'd12, OP_ENTER = 5'd13, OP_LEAVE = 5'd14, OP_PUSHR = 5'd15,
    OP_POPR = 5'd16, OP_PUSHS = 5'd17, OP_POPS = 5'd18, OP_PUSHF = 5'd19,
    OP_POPF = 5'd20, OP_PUSHA = 5'd21, OP_POPA = 5'd22, OP_PUSHI = 5'd23,
    OP_PUSHB = 5'd24, OP_SETREG = 5'd25
  } op_t;

  // IDLE -> (push or pop micro steps) -> DONE
  typedef enum logic [2:0] {
    S_IDLE, S_PUSH, S_POP, S_POPWAIT, S_ECOPY, S_ECOPYW, S_DONE
  } state_t;

  function automatic logic [15:0] sext8(input logic [15:0] w);
    return {{8{w[7]}}, w[7:0]};
  endfunction

endpackage

### design/cpu16_branch_and_stack_unit.sv
// Branch and stack unit: register file, stack memory and the sequencer.
// Depends on cbsu_pkg.
// Non-stack ops go straight to DONE; a pushed word takes PUSH, a popped word
// POP, POPWAIT (registered read); ENTER adds ECOPY, ECOPYW per copied level.
// Throughput: one item at a time; busy stays high through the strobe cycle.
// Reset clears the register file and the sequencer; stack memory is undefined.
// The result strobe cannot be stalled by the receiver.
module cpu16_branch_and_stack_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [4:0]  cmd,
  input  logic [15:0] imm_word,
  input  logic [15:0] imm_segment,
  input  logic [7:0]  nest_level,
  input  logic        cond_bit,
  input  logic [3:0]  reg_sel,
  output logic        strobe,
  output logic [15:0] pc_out,
  output logic [15:0] ps_out,
  output logic [15:0] sp_out,
  output logic [15:0] bp_out,
  output logic [15:0] count_out,
  output logic [15:0] flags_out,
  output logic        flush_out,
  output logic        irq_hold
);
  import cbsu_pkg::*;

  logic [15:0] regs [NREGS];
  logic [15:0] mem [STACK_WORDS];
  logic [15:0] rdata;

  state_t state, state_next;
  op_t    op;
  logic [15:0] imm, seg;
  logic [4:0]  lvl;
  logic [3:0]  rs;
  logic [3:0]  step;       // micro step within the op
  logic [4:0]  cnt;        // ENTER copy index
  logic [15:0] frame;
  logic        flush, hold;

  // Combinational controls
  logic        do_wr;
  logic [15:0] wdata;
  logic [SAW-1:0] addr;
  logic        rd_en;
  logic        reg_we;
  logic [3:0]  reg_wa;
  logic [15:0] reg_wd;
  logic        sp_we;
  logic [15:0] sp_wd;
  logic [3:0]  step_next;
  logic [4:0]  cnt_next;
  logic        flush_next, hold_next, frame_we;

  logic [15:0] sp, bp, pc, ps, psw, cw;
  assign sp = regs[R_SP];
  assign bp = regs[R_BP];
  assign pc = regs[R_PC];
  assign ps = regs[R_PS];
  assign psw = regs[R_PSW];
  assign cw = regs[R_CW];

  logic [15:0] sp_m2, sp_p2;
  assign sp_m2 = sp - 16'd2;
  assign sp_p2 = sp + 16'd2;

  // ENTER copies the word at BP - 2 * cnt
  logic [15:0] copy_addr;
  assign copy_addr = bp - {10'd0, cnt, 1'b0};

  // Value pushed at the current step
  logic [15:0] push_val;
  logic [15:0] rs_val;
  always_comb begin
    rs_val = (rs < 4'(NREGS)) ? regs[rs] : 16'd0;
    case (op)
      OP_CALLN: push_val = pc;
      OP_CALLF: push_val = (step == 4'd0) ? ps : pc;
      OP_ENTER: push_val = (step == 4'd0) ? bp : (step == 4'd1 ? rdata : frame);
      OP_PUSHR, OP_PUSHS: push_val = (rs == R_SP) ? sp_m2 : rs_val;
      OP_PUSHF: push_val = psw;
      OP_PUSHA: push_val = (step == 4'(R_SP)) ? frame : regs[step[2:0]];
      OP_PUSHI: push_val = imm;
      OP_PUSHB: push_val = sext8(imm);
      default: push_val = 16'd0;
    endcase
  end

  // pushes remaining after the current one
  logic more_push;
  always_comb begin
    case (op)
      OP_CALLF: more_push = (step == 4'd0);
      OP_PUSHA: more_push = (step != 4'd7);
      default:  more_push = 1'b0;
    endcase
  end

  // target register for a popped word
  logic [3:0] pop_reg;
  logic       pop_keep, more_pop;
  always_comb begin
    pop_keep = 1'b1;
    more_pop = 1'b0;
    pop_reg = R_PC;
    case (op)
      OP_RET, OP_RETI: pop_reg = R_PC;
      OP_RETF, OP_RETFI: begin
        pop_reg = (step == 4'd0) ? R_PC : R_PS;
        more_pop = (step == 4'd0);
      end
      OP_IRET: begin
        pop_reg = (step == 4'd0) ? R_PC : (step == 4'd1 ? R_PS : R_PSW);
        more_pop = (step != 4'd2);
      end
      OP_LEAVE: pop_reg = R_BP;
      OP_POPR, OP_POPS: begin
        pop_reg = rs;
        pop_keep = (rs < 4'(NREGS));
      end
      OP_POPF: pop_reg = R_PSW;
      OP_POPA: begin
        pop_reg = 4'd7 - step;
        pop_keep = (pop_reg != R_SP);
        more_pop = (step != 4'd7);
      end
      default: ;
    endcase
  end

  always_comb begin
    state_next = state;
    step_next = step;
    cnt_next = cnt;
    flush_next = flush;
    hold_next = hold;
    frame_we = 1'b0;
    do_wr = 1'b0;
    rd_en = 1'b0;
    wdata = push_val;
    addr = sp[SAW:1];
    reg_we = 1'b0;
    reg_wa = R_PC;
    reg_wd = 16'd0;
    sp_we = 1'b0;
    sp_wd = sp;
    case (state)
      S_IDLE: ;
      S_PUSH: begin
        do_wr = 1'b1;
        addr = sp_m2[SAW:1];
        sp_we = 1'b1;
        sp_wd = sp_m2;
        step_next = step + 4'd1;
        if (op == OP_ENTER) begin
          if (step == 4'd0) begin
            frame_we = 1'b1;
            if (lvl == 5'd0) begin
              state_next = S_DONE;
            end else if (lvl == 5'd1) begin
              step_next = 4'd2;
            end else begin
              cnt_next = 5'd1;
              state_next = S_ECOPY;
            end
          end else if (step == 4'd1) begin
            cnt_next = cnt + 5'd1;
            if (cnt + 5'd1 == lvl) step_next = 4'd2;
            else begin
              step_next = 4'd1;
              state_next = S_ECOPY;
            end
          end else begin
            state_next = S_DONE;
          end
        end else if (!more_push) begin
          state_next = S_DONE;
        end
      end
      S_ECOPY: begin
        rd_en = 1'b1;
        addr = copy_addr[SAW:1];
        step_next = 4'd1;
        state_next = S_ECOPYW;
      end
      S_ECOPYW: state_next = S_PUSH;
      S_POP: begin
        rd_en = 1'b1;
        state_next = S_POPWAIT;
      end
      S_POPWAIT: begin
        reg_we = pop_keep;
        reg_wa = pop_reg;
        reg_wd = rdata;
        sp_we = 1'b1;
        sp_wd = sp_p2;
        step_next = step + 4'd1;
        state_next = more_pop ? S_POP : S_DONE;
      end
      S_DONE: begin
        state_next = S_IDLE;
        case (op)
          OP_RETI, OP_RETFI: begin sp_we = 1'b1; sp_wd = sp + imm; end
          OP_ENTER: begin
            sp_we = 1'b1;
            sp_wd = sp - imm;
            reg_we = 1'b1;
            reg_wa = R_BP;
            reg_wd = frame;
          end
          default: ;
        endcase
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Decode at start: non-stack ops complete here
  logic [15:0] cw_m1;
  assign cw_m1 = cw - 16'd1;

  state_t dec_state;
  logic   dec_flush, dec_hold;
  always_comb begin
    dec_state = S_DONE;
    dec_flush = 1'b0;
    dec_hold = 1'b0;
    case (cmd)
      OP_LOOP, OP_LOOPW:
        dec_flush = (cw_m1 != 16'd0) && (cmd == OP_LOOP || psw[6] == cond_bit);
      OP_JSHORT, OP_JNEAR, OP_JFAR: dec_flush = 1'b1;
      OP_JCOND: dec_flush = cond_bit;
      OP_CALLN, OP_CALLF: begin
        dec_state = S_PUSH;
        dec_flush = 1'b1;
      end
      OP_ENTER, OP_PUSHR, OP_PUSHS, OP_PUSHF, OP_PUSHA, OP_PUSHI, OP_PUSHB:
        dec_state = S_PUSH;
      OP_RET, OP_RETI, OP_RETF, OP_RETFI: begin
        dec_state = S_POP;
        dec_flush = 1'b1;
      end
      OP_IRET: begin
        dec_state = S_POP;
        dec_flush = 1'b1;
        dec_hold = 1'b1;
      end
      OP_POPS: begin
        dec_state = S_POP;
        dec_hold = (reg_sel == R_SS);
      end
      OP_POPF: begin
        dec_state = S_POP;
        dec_hold = 1'b1;
      end
      OP_POPR, OP_POPA, OP_LEAVE: dec_state = S_POP;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      for (int i = 0; i < NREGS; i++) regs[i] <= 16'd0;
      flush <= 1'b0;
      hold <= 1'b0;
      step <= 4'd0;
      cnt <= 5'd0;
      strobe <= 1'b0;
    end else begin
      strobe <= (state == S_DONE);
      if (state == S_IDLE) begin
        // busy is still high during the strobe cycle
        if (start && !strobe) begin
          op <= op_t'(cmd);
          imm <= imm_word;
          seg <= imm_segment;
          lvl <= nest_level[4:0] & LEVEL_MASK;
          rs <= reg_sel;
          step <= 4'd0;
          flush <= dec_flush;
          hold <= dec_hold;
          frame <= sp;
          state <= dec_state;
          case (cmd)
            OP_LOOP, OP_LOOPW: begin
              regs[R_CW] <= cw_m1;
              if (dec_flush) regs[R_PC] <= pc + sext8(imm_word);
            end
            OP_JSHORT: regs[R_PC] <= pc + sext8(imm_word);
            OP_JCOND: if (cond_bit) regs[R_PC] <= pc + sext8(imm_word);
            OP_JNEAR: regs[R_PC] <= pc + imm_word;
            OP_JFAR: begin
              regs[R_PC] <= imm_word;
              regs[R_PS] <= imm_segment;
            end
            OP_LEAVE: regs[R_SP] <= bp;
            OP_SETREG: if (reg_sel < 4'(NREGS)) regs[reg_sel] <= imm_word;
            default: ;
          endcase
        end
      end else begin
        state <= state_next;
        step <= step_next;
        cnt <= cnt_next;
        flush <= flush_next;
        hold <= hold_next;
        if (frame_we) frame <= sp_m2;
        // a pop into SP keeps the popped word
        if (sp_we && !(reg_we && reg_wa == R_SP)) regs[R_SP] <= sp_wd;
        if (reg_we) regs[reg_wa] <= reg_wd;
        // far call: new PC and PS once both words are stored
        if (state == S_DONE && op == OP_CALLF) begin
          regs[R_PC] <= imm;
          regs[R_PS] <= seg;
        end
        if (state == S_DONE && op == OP_CALLN) regs[R_PC] <= pc + imm;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) mem[addr] <= wdata;
    if (rd_en) rdata <= mem[addr];
  end

  assign busy = (state != S_IDLE) || strobe;
  assign pc_out = pc;
  assign ps_out = ps;
  assign sp_out = sp;
  assign bp_out = bp;
  assign count_out = cw;
  assign flags_out = psw;
  assign flush_out = flush;
  assign irq_hold = hold;

  a_no_start_busy: assert property (@(posedge clk) disable iff (rst)
    strobe |-> busy) else $error("strobe without busy");
  a_strobe_after_done: assert property (@(posedge clk) disable iff (rst)
    strobe |-> $past(state == S_DONE)) else $error("strobe not from done");
  a_no_mem_conflict: assert property (@(posedge clk) disable iff (rst)
    !(do_wr && rd_en)) else $error("memory read and write together");
endmodule

### dv/tb_cpu16_branch_and_stack_unit.sv
// Testbench for cpu16_branch_and_stack_unit: directed and random instruction beats,
// each checked against an in-bench predictor of registers and stack memory.
// Depends on cbsu_pkg and the RTL top level.
module tb_cpu16_branch_and_stack_unit;
  import cbsu_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [15:0] pc, ps, sp, bp, cw, psw;
    logic        flush, hold;
  } arch_state_t;

  logic        clk = 1'b0, rst = 1'b1, start = 1'b0;
  logic        busy, strobe;
  logic [4:0]  cmd = '0;
  logic [15:0] imm_word = '0, imm_segment = '0;
  logic [7:0]  nest_level = '0;
  logic        cond_bit = 1'b0;
  logic [3:0]  reg_sel = '0;
  logic [15:0] pc_out, ps_out, sp_out, bp_out, count_out, flags_out;
  logic        flush_out, irq_hold;

  cpu16_branch_and_stack_unit uut (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // predictor state
  logic [15:0] arch_regs [NREGS];
  logic [15:0] stack_mem [STACK_WORDS];
  bit          stack_valid [STACK_WORDS];
  arch_state_t pending_results [$];
  int          errors = 0;

  function automatic int slot_of(input logic [15:0] addr);
    return int'(addr >> 1) % STACK_WORDS;
  endfunction

  function automatic logic [15:0] reg_read(input logic [3:0] r);
    return (r < NREGS) ? arch_regs[r] : 16'h0;
  endfunction

  function automatic void stack_push(input logic [15:0] v);
    arch_regs[R_SP] = arch_regs[R_SP] - 16'd2;
    stack_mem[slot_of(arch_regs[R_SP])] = v;
    stack_valid[slot_of(arch_regs[R_SP])] = 1'b1;
  endfunction

  function automatic logic [15:0] stack_pop();
    logic [15:0] v;
    v = stack_mem[slot_of(arch_regs[R_SP])];
    arch_regs[R_SP] = arch_regs[R_SP] + 16'd2;
    return v;
  endfunction

  function automatic logic [15:0] short_disp(input logic [15:0] w);
    return {{8{w[7]}}, w[7:0]};
  endfunction

  // True when every stack word the beat would read has been written.
  function automatic bit reads_written(input logic [4:0] c, input logic [7:0] lvl_b);
    logic [15:0] a;
    int n, lvl;
    n = 0;
    a = arch_regs[R_SP];
    case (c)
      OP_RET, OP_RETI, OP_POPR, OP_POPS, OP_POPF: n = 1;
      OP_RETF, OP_RETFI: n = 2;
      OP_IRET: n = 3;
      OP_POPA: n = 8;
      OP_LEAVE: begin
        n = 1;
        a = arch_regs[R_BP];
      end
      OP_ENTER: begin
        lvl = lvl_b & LEVEL_MASK;
        for (int i = 1; i < lvl; i++)
          if (!stack_valid[slot_of(arch_regs[R_BP] - 16'(i * 2))] &&
              slot_of(arch_regs[R_BP] - 16'(i * 2)) != slot_of(arch_regs[R_SP] - 16'd2))
            return 0;
      end
      default: ;
    endcase
    for (int i = 0; i < n; i++)
      if (!stack_valid[slot_of(a + 16'(i * 2))]) return 0;
    return 1;
  endfunction

  function automatic arch_state_t execute_instr(input logic [4:0] c, input logic [15:0] imm,
      input logic [15:0] seg, input logic [7:0] lvl_b, input logic cb, input logic [3:0] rs);
    arch_state_t r;
    logic flush, hold, zf;
    logic [15:0] frame, v, s;
    int lvl;
    flush = 0;
    hold = 0;
    lvl = lvl_b & LEVEL_MASK;
    case (c)
      OP_LOOP, OP_LOOPW: begin
        zf = arch_regs[R_PSW][6];
        arch_regs[R_CW] = arch_regs[R_CW] - 16'd1;
        if (arch_regs[R_CW] != 0 && (c == OP_LOOP || zf == cb)) begin
          arch_regs[R_PC] = arch_regs[R_PC] + short_disp(imm);
          flush = 1;
        end
      end
      OP_JSHORT: begin
        arch_regs[R_PC] = arch_regs[R_PC] + short_disp(imm);
        flush = 1;
      end
      OP_JCOND: if (cb) begin
        arch_regs[R_PC] = arch_regs[R_PC] + short_disp(imm);
        flush = 1;
      end
      OP_JNEAR: begin
        arch_regs[R_PC] = arch_regs[R_PC] + imm;
        flush = 1;
      end
      OP_JFAR: begin
        arch_regs[R_PS] = seg;
        arch_regs[R_PC] = imm;
        flush = 1;
      end
      OP_CALLN: begin
        stack_push(arch_regs[R_PC]);
        arch_regs[R_PC] = arch_regs[R_PC] + imm;
        flush = 1;
      end
      OP_CALLF: begin
        stack_push(arch_regs[R_PS]);
        stack_push(arch_regs[R_PC]);
        arch_regs[R_PS] = seg;
        arch_regs[R_PC] = imm;
        flush = 1;
      end
      OP_RET: begin
        arch_regs[R_PC] = stack_pop();
        flush = 1;
      end
      OP_RETI: begin
        arch_regs[R_PC] = stack_pop();
        arch_regs[R_SP] = arch_regs[R_SP] + imm;
        flush = 1;
      end
      OP_RETF, OP_RETFI: begin
        arch_regs[R_PC] = stack_pop();
        arch_regs[R_PS] = stack_pop();
        if (c == OP_RETFI) arch_regs[R_SP] = arch_regs[R_SP] + imm;
        flush = 1;
      end
      OP_IRET: begin
        arch_regs[R_PC] = stack_pop();
        arch_regs[R_PS] = stack_pop();
        arch_regs[R_PSW] = stack_pop();
        flush = 1;
        hold = 1;
      end
      OP_ENTER: begin
        stack_push(arch_regs[R_BP]);
        frame = arch_regs[R_SP];
        if (lvl != 0) begin
          for (int i = 1; i < lvl; i++)
            stack_push(stack_mem[slot_of(arch_regs[R_BP] - 16'(i * 2))]);
          stack_push(frame);
        end
        arch_regs[R_BP] = frame;
        arch_regs[R_SP] = arch_regs[R_SP] - imm;
      end
      OP_LEAVE: begin
        arch_regs[R_SP] = arch_regs[R_BP];
        arch_regs[R_BP] = stack_pop();
      end
      OP_PUSHR, OP_PUSHS:
        stack_push(rs == R_SP ? arch_regs[R_SP] - 16'd2 : reg_read(rs));
      OP_POPR, OP_POPS: begin
        v = stack_pop();
        if (rs < NREGS) arch_regs[rs] = v;
        if (c == OP_POPS && rs == R_SS) hold = 1;
      end
      OP_PUSHF: stack_push(arch_regs[R_PSW]);
      OP_POPF: begin
        arch_regs[R_PSW] = stack_pop();
        hold = 1;
      end
      OP_PUSHA: begin
        s = arch_regs[R_SP];
        for (int i = 0; i < 8; i++) stack_push(i == R_SP ? s : arch_regs[i]);
      end
      OP_POPA:
        for (int i = 7; i >= 0; i--) begin
          v = stack_pop();
          if (i != R_SP) arch_regs[i] = v;
        end
      OP_PUSHI: stack_push(imm);
      OP_PUSHB: stack_push(short_disp(imm));
      OP_SETREG: if (rs < NREGS) arch_regs[rs] = imm;
      default: ;
    endcase
    r.pc = arch_regs[R_PC];
    r.ps = arch_regs[R_PS];
    r.sp = arch_regs[R_SP];
    r.bp = arch_regs[R_BP];
    r.cw = arch_regs[R_CW];
    r.psw = arch_regs[R_PSW];
    r.flush = flush;
    r.hold = hold;
    return r;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Drive one beat; a beat that would read unwritten stack becomes a push of imm.
  task automatic issue(input logic [4:0] c, input logic [15:0] imm, input logic [15:0] seg,
      input logic [7:0] lvl, input logic cb, input logic [3:0] rs, input int gap);
    if (!reads_written(c, lvl)) c = OP_PUSHI;
    start <= 1'b1;
    cmd <= c;
    imm_word <= imm;
    imm_segment <= seg;
    nest_level <= lvl;
    cond_bit <= cb;
    reg_sel <= rs;
    do @(posedge clk); while (busy);
    pending_results.push_back(execute_instr(c, imm, seg, lvl, cb, rs));
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic set_reg(input logic [3:0] r, input logic [15:0] v);
    issue(OP_SETREG, v, 16'h0, 8'h0, 1'b0, r, pick_gap());
  endtask

  task automatic drain();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  always @(posedge clk) begin
    arch_state_t e, a;
    if (!rst && strobe) begin
      a = '{pc_out, ps_out, sp_out, bp_out, count_out, flags_out, flush_out, irq_hold};
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result beat %p", $time, a);
        errors++;
      end else begin
        e = pending_results.pop_front();
        if (a !== e) begin
          $display("%0t: mismatch expected %p actual %p", $time, e, a);
          errors++;
        end
      end
    end
  end

  task automatic test_jumps();
    set_reg(R_PC, 16'h1000);
    issue(OP_JSHORT, 16'h007f, 0, 0, 0, 0, 0);
    issue(OP_JSHORT, 16'hff80, 0, 0, 0, 0, 1);
    issue(OP_JCOND, 16'h0010, 0, 0, 1, 0, 0);
    issue(OP_JCOND, 16'h0010, 0, 0, 0, 0, 2);
    issue(OP_JNEAR, 16'hffff, 0, 0, 0, 0, 0);
    issue(OP_JFAR, 16'hffff, 16'hffff, 0, 0, 0, 0);
    issue(OP_JFAR, 16'h0000, 16'h0000, 0, 0, 0, 0);
    for (int c = 26; c < 32; c++) issue(5'(c), 16'hffff, 16'hffff, 8'hff, 1, 4'hf, 0);
  endtask

  task automatic test_loops();
    set_reg(R_CW, 16'd2);
    set_reg(R_PSW, 16'h0040);
    issue(OP_LOOP, 16'h0005, 0, 0, 0, 0, 0);   // taken
    issue(OP_LOOP, 16'h0005, 0, 0, 0, 0, 0);   // count hits zero
    issue(OP_LOOP, 16'h00f0, 0, 0, 0, 0, 0);   // wraps to ffff, taken
    issue(OP_LOOPW, 16'h0003, 0, 0, 1, 0, 0);
    issue(OP_LOOPW, 16'h0003, 0, 0, 0, 0, 0);
  endtask

  task automatic test_calls_returns();
    set_reg(R_SP, 16'h0000);
    issue(OP_CALLN, 16'h0100, 0, 0, 0, 0, 0);
    issue(OP_RET, 0, 0, 0, 0, 0, 0);
    issue(OP_CALLF, 16'h2000, 16'h3000, 0, 0, 0, 0);
    issue(OP_RETF, 0, 0, 0, 0, 0, 0);
    issue(OP_PUSHF, 0, 0, 0, 0, 0, 0);
    issue(OP_CALLF, 16'h4000, 16'h5000, 0, 0, 0, 0);
    issue(OP_IRET, 0, 0, 0, 0, 0, 0);
    issue(OP_CALLN, 16'h0010, 0, 0, 0, 0, 0);
    issue(OP_RETI, 16'h0004, 0, 0, 0, 0, 0);
    issue(OP_CALLF, 16'h0010, 16'h0020, 0, 0, 0, 0);
    issue(OP_RETFI, 16'hfffc, 0, 0, 0, 0, 0);
  endtask

  task automatic test_stack_regs();
    issue(OP_PUSHR, 0, 0, 0, 0, R_SP, 0);      // stores SP-2
    issue(OP_POPR, 0, 0, 0, 0, R_SP, 0);
    issue(OP_PUSHR, 0, 0, 0, 0, 4'hf, 0);      // out-of-range selector reads zero
    issue(OP_POPR, 0, 0, 0, 0, 4'he, 0);
    issue(OP_PUSHS, 0, 0, 0, 0, R_SS, 0);
    issue(OP_POPS, 0, 0, 0, 0, R_SS, 0);
    issue(OP_PUSHI, 16'h1234, 0, 0, 0, 0, 0);
    issue(OP_POPR, 0, 0, 0, 0, R_PC, 0);
    issue(OP_PUSHB, 16'h0080, 0, 0, 0, 0, 0);
    issue(OP_POPF, 0, 0, 0, 0, 0, 0);
    issue(OP_PUSHA, 0, 0, 0, 0, 0, 0);
    issue(OP_POPA, 0, 0, 0, 0, 0, 0);
  endtask

  task automatic test_enter_leave();
    set_reg(R_SP, 16'h8000);
    issue(OP_ENTER, 16'h0010, 0, 8'h00, 0, 0, 0);
    issue(OP_ENTER, 16'h0004, 0, 8'h01, 0, 0, 0);
    issue(OP_ENTER, 16'h0000, 0, 8'h03, 0, 0, 0);
    issue(OP_ENTER, 16'hffff, 0, 8'he4, 0, 0, 0); // level masked to 4
    issue(OP_LEAVE, 0, 0, 0, 0, 0, 0);
    issue(OP_LEAVE, 0, 0, 0, 0, 0, 0);
    drain();
  endtask

  task automatic test_random();
    logic [4:0] c;
    int r, burst;
    burst = 0;
    for (int n = 0; n < 600; n++) begin
      r = $urandom_range(0, 99);
      if (r < 6) c = OP_SETREG;
      else if (r < 9) c = 5'($urandom_range(26, 31));
      else c = 5'($urandom_range(0, 24));
      if (c == OP_SETREG && $urandom_range(0, 3) == 0)
        issue(c, 16'($urandom_range(0, 3)), 0, 0, 0, R_CW, 0);
      else
        issue(c, 16'($urandom), 16'($urandom), 8'($urandom), 1'($urandom),
              4'($urandom), burst > 0 ? 0 : pick_gap());
      if (burst > 0) burst--;
      else if ($urandom_range(0, 49) == 0) burst = 20;
      if (n == 300) drain();
    end
  endtask

  initial begin
    for (int i = 0; i < NREGS; i++) arch_regs[i] = '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_jumps();
    test_loops();
    test_calls_returns();
    test_stack_regs();
    test_enter_leave();
    test_random();
    drain();
    repeat (200) @(posedge clk);
    if (errors == 0 && pending_results.size() == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    #2ms;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
